@@ hw/rtl/mzg_pkg.sv @@
// Shared types and constants for the maze grid generator.
`default_nettype none

package mzg_pkg;

    // Field widths fixed by the port list
    localparam int SEED_W  = 18;
    localparam int COORD_W = 6;
    localparam int ROW_BITS = 43;

    // Lehmer generator: state = state * MUL mod MOD
    localparam int MUL_W  = 16;
    localparam int PROD_W = SEED_W + MUL_W;
    localparam logic [MUL_W-1:0]  LEHMER_MUL = MUL_W'(48217);
    localparam logic [SEED_W-1:0] LEHMER_MOD = SEED_W'(142857);
    // Largest quotient of a product is below 2^17, so shifts run 16 down to 0
    localparam int RED_W = 5;
    localparam logic [RED_W-1:0] RED_TOP = RED_W'(16);

    // Carver headings
    localparam logic [1:0] HEAD_PX = 2'd0;
    localparam logic [1:0] HEAD_PY = 2'd1;
    localparam logic [1:0] HEAD_NX = 2'd2;
    localparam logic [1:0] HEAD_NY = 2'd3;

    typedef logic [SEED_W-1:0]  t_seed;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [ROW_BITS-1:0] t_row;

endpackage

`default_nettype wire

@@ hw/rtl/maze_grid_generator.sv @@
// Maze grid generator top level: carving sequencer, wall map and row readout.
//
// Usage: pulse i_start with a seed on i_seed while o_busy is low; the seed is
// transferred on that edge. The block then fills the wall map, runs one carver
// from every odd cell in raster order and opens the entry and exit. Each
// heading draw in the Lehmer unit is a multiply, shift-subtract steps for
// shifts 16 down to 0, then a handoff; a carving step is a draw followed by
// two reads, a compare and two writes, and a failed turn ends at the bound
// check or after both reads. Readout walks the single-port wall map one cell
// a cycle. Heading draws set the carving time; the wall map port sets fill
// and readout.
// Results: MAZE_DIM rows, each shown for one cycle with o_row_valid high;
// o_last_row marks the final row. The receiver cannot stall; every row must
// be taken when strobed. o_busy stays high from the transfer until the cycle
// in which the last row is strobed.
// Reset clears the sequencer and the generator state; the wall map needs no
// clearing since each seed rewrites all of it before any read.
`default_nettype none

module maze_grid_generator #(
    parameter int MAZE_DIM = 43
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire mzg_pkg::t_seed i_seed,
    output logic                o_busy,
    output logic                o_row_valid,
    output mzg_pkg::t_coord     o_row_index,
    output mzg_pkg::t_row       o_row_walls,
    output logic                o_last_row
);

    localparam int CW     = mzg_pkg::COORD_W;
    localparam int CELLS  = MAZE_DIM * MAZE_DIM;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [CW:0]       DIM_X     = (CW + 1)'(MAZE_DIM);
    localparam logic [CW-1:0]     LAST_C    = CW'(MAZE_DIM - 1);
    localparam logic [CW-1:0]     EXIT_C    = CW'(MAZE_DIM - 2);
    localparam logic [ADDR_W-1:0] DIM_A     = ADDR_W'(MAZE_DIM);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_OPEN  = 4'd2;
    localparam logic [3:0] ST_DRAW  = 4'd3;
    localparam logic [3:0] ST_WAIT  = 4'd4;
    localparam logic [3:0] ST_CHECK = 4'd5;
    localparam logic [3:0] ST_RD1   = 4'd6;
    localparam logic [3:0] ST_RD2   = 4'd7;
    localparam logic [3:0] ST_WR1   = 4'd8;
    localparam logic [3:0] ST_WR2   = 4'd9;
    localparam logic [3:0] ST_ENTRY = 4'd10;
    localparam logic [3:0] ST_EXIT  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;
    localparam logic [3:0] ST_DRAIN = 4'd13;

    logic [3:0]        r_state;
    logic [ADDR_W-1:0] r_fill;
    mzg_pkg::t_coord   r_sc, r_sr;      // start cell
    mzg_pkg::t_coord   r_cc, r_cr;      // carver cell
    logic [1:0]        r_head;
    logic [1:0]        r_fails;
    logic              r_w1;
    mzg_pkg::t_coord   r_orow, r_ocol;  // readout cursor
    logic              r_pend;
    mzg_pkg::t_coord   r_prow, r_pcol;  // cell whose read data returns now
    mzg_pkg::t_row     r_bits;
    logic              r_vld;
    mzg_pkg::t_coord   r_oidx;
    mzg_pkg::t_row     r_owalls;
    logic              r_olast;

    logic              w_done;
    mzg_pkg::t_seed    w_gen;
    logic [0:0]        w_rdata;

    // Wall map
    logic              w_we;
    logic [0:0]        w_wdata;
    logic [ADDR_W-1:0] w_addr;
    logic              w_use_fill;
    mzg_pkg::t_coord   w_sel_r, w_sel_c;

    mzg_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_wall_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    mzg_lehmer u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_state == ST_IDLE && i_start),
        .i_seed  (i_seed),
        .i_draw  (r_state == ST_DRAW),
        .o_done  (w_done),
        .o_state (w_gen)
    );

    // Step geometry for the current heading
    mzg_pkg::t_coord w_c1, w_r1, w_c2, w_r2;
    logic            w_inb;

    always_comb begin
        w_c1  = r_cc;
        w_r1  = r_cr;
        w_c2  = r_cc;
        w_r2  = r_cr;
        w_inb = 1'b0;
        unique case (r_head)
            mzg_pkg::HEAD_PX: begin
                w_c1  = r_cc + CW'(1);
                w_c2  = r_cc + CW'(2);
                w_inb = ({1'b0, r_cc} + (CW + 1)'(2)) < DIM_X;
            end
            mzg_pkg::HEAD_PY: begin
                w_r1  = r_cr + CW'(1);
                w_r2  = r_cr + CW'(2);
                w_inb = ({1'b0, r_cr} + (CW + 1)'(2)) < DIM_X;
            end
            mzg_pkg::HEAD_NX: begin
                w_c1  = r_cc - CW'(1);
                w_c2  = r_cc - CW'(2);
                w_inb = r_cc > CW'(2);
            end
            mzg_pkg::HEAD_NY: begin
                w_r1  = r_cr - CW'(1);
                w_r2  = r_cr - CW'(2);
                w_inb = r_cr > CW'(2);
            end
        endcase
    end

    // Next carver start in raster order
    logic w_more_col, w_more_row;
    assign w_more_col = ({1'b0, r_sc} + (CW + 1)'(2)) < DIM_X;
    assign w_more_row = ({1'b0, r_sr} + (CW + 1)'(2)) < DIM_X;

    // Wall map port selection
    always_comb begin
        w_we       = 1'b0;
        w_wdata    = 1'b0;
        w_use_fill = 1'b0;
        w_sel_r    = '0;
        w_sel_c    = '0;
        unique case (r_state)
            ST_FILL: begin
                w_we       = 1'b1;
                w_wdata    = 1'b1;
                w_use_fill = 1'b1;
            end
            ST_OPEN: begin
                w_we    = 1'b1;
                w_sel_r = CW'(1);
                w_sel_c = CW'(1);
            end
            ST_CHECK: begin
                w_sel_r = w_r1;
                w_sel_c = w_c1;
            end
            ST_RD1: begin
                w_sel_r = w_r2;
                w_sel_c = w_c2;
            end
            ST_WR1: begin
                w_we    = 1'b1;
                w_sel_r = w_r1;
                w_sel_c = w_c1;
            end
            ST_WR2: begin
                w_we    = 1'b1;
                w_sel_r = w_r2;
                w_sel_c = w_c2;
            end
            ST_ENTRY: begin
                w_we    = 1'b1;
                w_sel_c = CW'(1);
            end
            ST_EXIT: begin
                w_we    = 1'b1;
                w_sel_r = LAST_C;
                w_sel_c = EXIT_C;
            end
            ST_OUT: begin
                w_sel_r = r_orow;
                w_sel_c = r_ocol;
            end
            default: begin
            end
        endcase
        w_addr = w_use_fill ? r_fill
                            : ADDR_W'(ADDR_W'(w_sel_r) * DIM_A + ADDR_W'(w_sel_c));
    end

    // Failed turn: rotate in place, and after four move on to the next start
    logic [3:0]      n_fail_state;
    logic [1:0]      n_fails;
    mzg_pkg::t_coord n_sc, n_sr;
    mzg_pkg::t_coord n_cc, n_cr;

    always_comb begin
        n_sc    = r_sc;
        n_sr    = r_sr;
        n_cc    = r_cc;
        n_cr    = r_cr;
        n_fails = r_fails + 2'd1;
        n_fail_state = ST_CHECK;
        if (r_fails == 2'd3) begin
            n_fails = '0;
            priority if (w_more_col) begin
                n_sc = r_sc + CW'(2);
                n_cc = r_sc + CW'(2);
                n_cr = r_sr;
                n_fail_state = ST_DRAW;
            end else if (w_more_row) begin
                n_sc = CW'(1);
                n_sr = r_sr + CW'(2);
                n_cc = CW'(1);
                n_cr = r_sr + CW'(2);
                n_fail_state = ST_DRAW;
            end else begin
                n_fail_state = ST_ENTRY;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_sc    <= '0;
            r_sr    <= '0;
            r_cc    <= '0;
            r_cr    <= '0;
            r_head  <= '0;
            r_fails <= '0;
            r_orow  <= '0;
            r_ocol  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_fill  <= '0;
                        r_state <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    if (r_fill == LAST_CELL) begin
                        r_state <= ST_OPEN;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                ST_OPEN: begin
                    r_sc    <= CW'(1);
                    r_sr    <= CW'(1);
                    r_cc    <= CW'(1);
                    r_cr    <= CW'(1);
                    r_state <= ST_DRAW;
                end
                ST_DRAW: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_done) begin
                        r_head  <= w_gen[1:0];
                        r_fails <= '0;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (w_inb) begin
                        r_state <= ST_RD1;
                    end else begin
                        r_head  <= r_head + 2'd1;
                        r_fails <= n_fails;
                        r_sc    <= n_sc;
                        r_sr    <= n_sr;
                        r_cc    <= n_cc;
                        r_cr    <= n_cr;
                        r_state <= n_fail_state;
                    end
                end
                ST_RD1: begin
                    r_state <= ST_RD2;
                end
                ST_RD2: begin
                    if (r_w1 && w_rdata[0]) begin
                        r_state <= ST_WR1;
                    end else begin
                        r_head  <= r_head + 2'd1;
                        r_fails <= n_fails;
                        r_sc    <= n_sc;
                        r_sr    <= n_sr;
                        r_cc    <= n_cc;
                        r_cr    <= n_cr;
                        r_state <= n_fail_state;
                    end
                end
                ST_WR1: begin
                    r_state <= ST_WR2;
                end
                ST_WR2: begin
                    r_cc    <= w_c2;
                    r_cr    <= w_r2;
                    r_state <= ST_DRAW;
                end
                ST_ENTRY: begin
                    r_state <= ST_EXIT;
                end
                ST_EXIT: begin
                    r_orow  <= '0;
                    r_ocol  <= '0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (r_ocol == LAST_C) begin
                        r_ocol <= '0;
                        if (r_orow == LAST_C) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_orow <= r_orow + CW'(1);
                        end
                    end else begin
                        r_ocol <= r_ocol + CW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // First cell of a step, captured from its registered read data in ST_RD1
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD1) begin
            r_w1 <= w_rdata[0];
        end
    end

    // Row assembly: merge returning read data into the row word
    mzg_pkg::t_row n_bits;

    always_comb begin
        for (int j = 0; j < mzg_pkg::ROW_BITS; j++) begin
            n_bits[j] = r_bits[j] | (w_rdata[0] && r_pcol == CW'(j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_pend <= (r_state == ST_OUT);
            r_vld  <= r_pend && r_pcol == LAST_C;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prow <= r_orow;
        r_pcol <= r_ocol;
        if (r_state == ST_EXIT) begin
            r_bits <= '0;
        end else if (r_pend) begin
            if (r_pcol == LAST_C) begin
                r_bits   <= '0;
                r_owalls <= n_bits;
                r_oidx   <= r_prow;
                r_olast  <= r_prow == LAST_C;
            end else begin
                r_bits <= n_bits;
            end
        end
    end

    assign o_busy      = r_state != ST_IDLE;
    assign o_row_valid = r_vld;
    assign o_row_index = r_oidx;
    assign o_row_walls = r_owalls;
    assign o_last_row  = r_olast;

endmodule

`default_nettype wire

@@ hw/rtl/mzg_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module mzg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1849
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/mzg_lehmer.sv @@
// Lehmer generator with a multiply stage and a shift-subtract modulo unit.
`default_nettype none

module mzg_lehmer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire mzg_pkg::t_seed i_seed,
    input  wire logic          i_draw,
    output logic               o_done,
    output mzg_pkg::t_seed     o_state
);

    localparam int PW = mzg_pkg::PROD_W;

    mzg_pkg::t_seed              r_state;
    logic                        r_busy;
    logic                        r_done;
    logic [mzg_pkg::RED_W-1:0]   r_k;
    logic [PW-1:0]               r_rem;

    logic [PW:0]   w_sub;
    logic          w_ge;
    logic [PW-1:0] n_rem;

    // One restoring step: subtract MOD << k when it fits
    always_comb begin
        w_sub = (PW + 1)'(mzg_pkg::LEHMER_MOD) << r_k;
        w_ge  = {1'b0, r_rem} >= w_sub;
        n_rem = w_ge ? PW'({1'b0, r_rem} - w_sub) : r_rem;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_state <= i_seed;
            end else if (i_draw) begin
                r_busy <= 1'b1;
                r_k    <= mzg_pkg::RED_TOP;
            end else if (r_busy) begin
                if (r_k == '0) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_state <= n_rem[mzg_pkg::SEED_W-1:0];
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    // Product and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_draw) begin
            r_rem <= PW'(r_state) * PW'(mzg_pkg::LEHMER_MUL);
        end else if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_done  = r_done;
    assign o_state = r_state;

endmodule

`default_nettype wire

@@ bench/maze_grid_generator_tb.sv @@
// Self-checking testbench for the maze grid generator: seeds in, maze rows checked.
module maze_grid_generator_tb;
    import mzg_pkg::*;

    localparam int MAZE_DIM         = 43;
    localparam int RANDOM_PER_PHASE = 22;
    localparam int DRAIN_CYCLES     = 4 * MAZE_DIM;
    // Watchdog limit in time units, covering all 101 seeds
    localparam int TIMEOUT_UNITS    = 40_000_000;
    localparam int MAX_PRINTS       = 100;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    t_seed           i_seed  = '0;
    logic            o_busy;
    logic            o_row_valid;
    t_coord          o_row_index;
    t_row            o_row_walls;
    logic            o_last_row;

    typedef struct {
        t_coord index;
        t_row   walls;
        logic   last;
    } maze_row_t;

    // Zero to three, bit patterns, the multiplier, 2^17 and 2^16-1, the modulus edges and the all-ones seed
    t_seed directed_seeds [13] = '{
        18'd0, 18'd1, 18'd2, 18'd3, 18'h2AAAA, 18'h15555, 18'd48217,
        18'd142856, 18'd142857, 18'd142858, 18'd131072, 18'd65535, 18'h3FFFF
    };
    int phase_idle_pct [4] = '{0, 73, 0, 23};

    // Maze predictor and row scoreboard
    class maze_scoreboard;
        bit        cell_wall [MAZE_DIM][MAZE_DIM];
        t_seed     gen_state;
        maze_row_t rows_due [$];
        int        mismatches;
        int        rows_checked;
        int        mazes_noted;
        int        seeds_above_mod;

        // Lehmer step, product kept exact
        function logic [1:0] next_heading();
            longint unsigned prod;
            prod = longint'(gen_state) * longint'(LEHMER_MUL);
            gen_state = t_seed'(prod % longint'(LEHMER_MOD));
            return gen_state[1:0];
        endfunction

        // One carver walk from an odd start cell
        function void carve_from(int start_col, int start_row);
            int         col;
            int         row;
            int         dx;
            int         dy;
            int         c1;
            int         r1;
            int         c2;
            int         r2;
            int         fails;
            logic [1:0] head;
            col   = start_col;
            row   = start_row;
            head  = next_heading();
            fails = 0;
            while (fails < 4) begin
                dx = 0;
                dy = 0;
                case (head)
                    HEAD_PX: dx = 1;
                    HEAD_PY: dy = 1;
                    HEAD_NX: dx = -1;
                    default: dy = -1;
                endcase
                c1 = col + dx;
                r1 = row + dy;
                c2 = c1 + dx;
                r2 = r1 + dy;
                if (c2 > 0 && c2 < MAZE_DIM && r2 > 0 && r2 < MAZE_DIM
                    && cell_wall[r1][c1] && cell_wall[r2][c2]) begin
                    cell_wall[r1][c1] = 1'b0;
                    cell_wall[r2][c2] = 1'b0;
                    col   = c2;
                    row   = r2;
                    head  = next_heading();
                    fails = 0;
                end else begin
                    head  = head + 2'd1;
                    fails++;
                end
            end
        endfunction

        // Seed transferred: build the maze and queue its rows
        function void note_seed(t_seed seed);
            maze_row_t due;
            gen_state = seed;
            if (seed >= LEHMER_MOD)
                seeds_above_mod++;
            foreach (cell_wall[r, c])
                cell_wall[r][c] = 1'b1;
            cell_wall[1][1] = 1'b0;
            for (int r = 1; r < MAZE_DIM; r += 2)
                for (int c = 1; c < MAZE_DIM; c += 2)
                    carve_from(c, r);
            // entry and exit
            cell_wall[0][1] = 1'b0;
            cell_wall[MAZE_DIM-1][MAZE_DIM-2] = 1'b0;
            for (int r = 0; r < MAZE_DIM; r++) begin
                due.index = t_coord'(r);
                due.walls = '0;
                for (int c = 0; c < MAZE_DIM && c < ROW_BITS; c++)
                    due.walls[c] = cell_wall[r][c];
                due.last = (r == MAZE_DIM - 1);
                rows_due.push_back(due);
            end
            mazes_noted++;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("ERROR @%0t: %s", $time, what);
        endtask

        // Row strobed: compare with the oldest row due
        task check_row(t_coord index, t_row walls, logic last);
            maze_row_t due;
            if (rows_due.size() == 0) begin
                report_mismatch($sformatf("row %0d strobed with no row due", index));
                return;
            end
            due = rows_due.pop_front();
            rows_checked++;
            if (index !== due.index)
                report_mismatch($sformatf("row index %0d, wanted %0d", index, due.index));
            if (walls !== due.walls)
                report_mismatch($sformatf("row %0d walls %h, wanted %h",
                                          due.index, walls, due.walls));
            if (last !== due.last)
                report_mismatch($sformatf("row %0d last flag %b, wanted %b",
                                          due.index, last, due.last));
        endtask
    endclass

    maze_scoreboard board = new();

    maze_grid_generator #(
        .MAZE_DIM(MAZE_DIM)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_seed      (i_seed),
        .o_busy      (o_busy),
        .o_row_valid (o_row_valid),
        .o_row_index (o_row_index),
        .o_row_walls (o_row_walls),
        .o_last_row  (o_last_row)
    );

    always #1 i_clk = ~i_clk;

    // Watch both sides at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_row_valid === 1'b1)
            board.check_row(o_row_index, o_row_walls, o_last_row);
        if (i_rst_n && i_start && o_busy === 1'b0)
            board.note_seed(i_seed);
    end

    // Offer a seed until it is transferred; idle cycles in between carry junk seeds
    task send_seed(t_seed seed, int idle_pct);
        bit sent;
        sent = 1'b0;
        while (!sent) begin
            @(negedge i_clk);
            if ($urandom_range(99, 0) < idle_pct) begin
                i_start <= 1'b0;
                i_seed  <= t_seed'($urandom);
            end else begin
                i_start <= 1'b1;
                i_seed  <= seed;
                @(posedge i_clk);
                sent = (o_busy === 1'b0);
            end
        end
    endtask

    // Half in the generator range, half anywhere in the field
    function t_seed random_seed();
        if ($urandom_range(1, 0))
            return t_seed'($urandom_range(int'(LEHMER_MOD) - 1, 0));
        return t_seed'($urandom);
    endfunction

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_seeds[i])
            send_seed(directed_seeds[i], 0);

        foreach (phase_idle_pct[p])
            repeat (RANDOM_PER_PHASE)
                send_seed(random_seed(), phase_idle_pct[p]);

        @(negedge i_clk);
        i_start <= 1'b0;

        while (board.rows_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d mazes (%0d seeds at or above the modulus), %0d rows checked,",
                 board.mazes_noted, board.seeds_above_mod, board.rows_checked);
        $display("with sender idling at 0, 73 and 23 percent; %0d mismatches.",
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_UNITS);
        $display("Timed out with %0d rows still due.", board.rows_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
